FILE: rtl/core/bba_pkg.sv
// Shared types and constants for the block bitmap allocator.
// No dependencies; compile first.
package bba_pkg;

  localparam int BLK_W      = 17;
  localparam int ST_W       = 2;
  localparam int CFG_W      = 2;
  localparam int WORD_W     = 64;
  localparam int BIT_IDX_W  = 6;

  typedef logic [BLK_W-1:0]  blk_t;
  typedef logic [ST_W-1:0]   status_t;
  typedef logic              action_t;
  typedef logic [CFG_W-1:0]  cfg_t;
  typedef logic [WORD_W-1:0] word_t;

  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_NOSPACE = 2'd1;
  localparam status_t ST_RANGE   = 2'd2;

  localparam action_t ACT_ALLOC = 1'b0;
  localparam action_t ACT_FREE  = 1'b1;

  localparam cfg_t NB_RESET = 2'd1;

endpackage

FILE: rtl/core/bba_ifs.sv
// Valid/ready channel interfaces for requests, responses and configuration.
// Depends on bba_pkg.
interface bba_req_if;
  import bba_pkg::*;
  logic    valid;
  logic    ready;
  action_t action;
  blk_t    block_number;
  modport source (output valid, action, block_number, input ready);
  modport sink   (input valid, action, block_number, output ready);
endinterface

interface bba_rsp_if;
  import bba_pkg::*;
  logic    valid;
  logic    ready;
  blk_t    result_block;
  status_t status;
  modport source (output valid, result_block, status, input ready);
  modport sink   (input valid, result_block, status, output ready);
endinterface

interface bba_cfg_if;
  import bba_pkg::*;
  logic valid;
  logic ready;
  cfg_t data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

FILE: rtl/core/bba_ram.sv
// Simple dual-port synchronous RAM, one write and one read port, registered read.
// No package dependency.
module bba_ram #(
  parameter  int W  = 64,
  parameter  int D  = 1024,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/bba_ffz.sv
// Find-first-zero encoder: lowest clear bit of a vector, as one-hot and index.
// No package dependency.
module bba_ffz #(
  parameter  int W  = 64,
  localparam int IW = (W > 1) ? $clog2(W) : 1
) (
  input  logic [W-1:0]  vec,
  output logic          found,
  output logic [IW-1:0] idx,
  output logic [W-1:0]  onehot
);

  logic [W-1:0] inv;

  // isolate the lowest set bit of the inverted vector
  assign inv    = ~vec;
  assign onehot = inv & (~inv + W'(1));
  assign found  = |inv;

  always_comb begin
    idx = '0;
    for (int k = 0; k < IW; k++) begin
      for (int i = 0; i < W; i++) begin
        if (onehot[i] && (((i >> k) & 1) != 0)) begin
          idx[k] = 1'b1;
        end
      end
    end
  end

endmodule

FILE: rtl/core/block_bitmap_allocator_core.sv
// First-fit block bitmap allocator: word storage, full-word map and control sequencer.
// Depends on bba_pkg, bba_ifs, bba_ram and bba_ffz.
//
// The used/free bitmap lives in a 64-bit-wide word RAM of
// WORDS_PER_BITMAP_BLOCK * MAX_BITMAP_BLOCKS entries. A second RAM keeps one
// "word is full" bit per bitmap word, packed 64 to a row, and a flop vector
// keeps one "row is full" bit per row. An allocate request picks the first
// non-full row from the flop vector and reads that row, picks the first
// non-full word from it and reads the word, then sets its lowest clear bit and
// writes the word back (plus the full-map row when the word fills up). The
// result is 1 + bitmap_blocks + 64 * word + bit, masked to 17 bits. A free
// request checks the range, reads the word and its full-map row, and clears
// both bits. One request is in flight at a time. An allocate steps through
// S_A_GRP, S_A_ROW and S_A_WORD and an in-range free through S_F_CHK and
// S_F_WORD, following the chain of registered RAM reads; a rejected free
// ends in S_F_CHK, an out-of-space allocate in S_A_GRP or S_A_ROW. A result
// goes to an output register, so the next request is accepted while it
// waits; a request that finishes while that register is still occupied
// holds until the response is taken. After reset a clearing pass runs over
// the word RAM, one entry per cycle, with in_req.ready low; configuration
// writes are taken at all times and must be issued only while idle.
module block_bitmap_allocator_core #(
  parameter int WORDS_PER_BITMAP_BLOCK = 512,
  parameter int MAX_BITMAP_BLOCKS      = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  bba_cfg_if.sink     cfg_wr,
  bba_req_if.sink     in_req,
  bba_rsp_if.source   out_rsp
);
  import bba_pkg::*;

  localparam int TOTAL_WORDS = WORDS_PER_BITMAP_BLOCK * MAX_BITMAP_BLOCKS;
  localparam int NGROUPS     = (TOTAL_WORDS + WORD_W - 1) / WORD_W;
  localparam int WAW         = (TOTAL_WORDS > 1) ? $clog2(TOTAL_WORDS) : 1;
  localparam int GAW         = (NGROUPS > 1) ? $clog2(NGROUPS) : 1;
  localparam int WBITS       = GAW + BIT_IDX_W;
  localparam int WCNT_W      = $clog2(TOTAL_WORDS + 1);
  localparam int C1          = (WBITS > WCNT_W) ? WBITS : WCNT_W;
  localparam int FREE_W_W    = BLK_W - BIT_IDX_W;
  localparam int CW          = (C1 > FREE_W_W) ? C1 : FREE_W_W;
  localparam int SW          = ((WBITS + BIT_IDX_W > BLK_W) ? WBITS + BIT_IDX_W : BLK_W) + 1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_A_GRP,
    S_A_ROW,
    S_A_WORD,
    S_F_CHK,
    S_F_WORD,
    S_RESP
  } state_t;

  // Sequencer registers
  state_t             state_r, state_nxt;
  logic [WAW-1:0]     clr_r, clr_nxt;
  cfg_t               nb_r, nb_nxt;
  logic [CW-1:0]      words_r, words_nxt;
  blk_t               blk_r, blk_nxt;
  logic [GAW-1:0]     grp_r, grp_nxt;
  logic [CW-1:0]      wsel_r, wsel_nxt;
  logic [BIT_IDX_W-1:0] bit_r, bit_nxt;
  word_t              row_r, row_nxt;
  logic [NGROUPS-1:0] full_grp_r, full_grp_nxt;
  logic               out_valid_r, out_valid_nxt;
  blk_t               out_blk_r, out_blk_nxt;
  status_t            out_st_r, out_st_nxt;
  blk_t               res_blk_r, res_blk_nxt;
  status_t            res_st_r, res_st_nxt;

  // RAM ports
  logic           bm_we;
  logic [WAW-1:0] bm_waddr, bm_raddr;
  word_t          bm_wdata, bm_rdata;
  logic           fm_we;
  logic [GAW-1:0] fm_waddr, fm_raddr;
  word_t          fm_wdata, fm_rdata;

  // Encoders
  logic                 grp_found;
  logic [GAW-1:0]       grp_idx;
  logic                 row_found;
  logic [BIT_IDX_W-1:0] row_idx;
  logic                 word_found;
  logic [BIT_IDX_W-1:0] bit_idx;
  word_t                bit_onehot;

  // Datapath helpers
  logic           fin;
  blk_t           fin_blk;
  status_t        fin_st;
  cfg_t           nb_sat;
  logic [CW-1:0]  row_word;
  word_t          new_word;
  word_t          new_row;
  logic [SW-1:0]  alloc_sum;
  blk_t           free_base;
  blk_t           free_ind;
  logic [CW-1:0]  free_word;

  bba_ram #(.W(WORD_W), .D(TOTAL_WORDS)) u_word_ram (
    .clk   (clk),
    .we    (bm_we),
    .waddr (bm_waddr),
    .wdata (bm_wdata),
    .raddr (bm_raddr),
    .rdata (bm_rdata)
  );

  bba_ram #(.W(WORD_W), .D(NGROUPS)) u_full_ram (
    .clk   (clk),
    .we    (fm_we),
    .waddr (fm_waddr),
    .wdata (fm_wdata),
    .raddr (fm_raddr),
    .rdata (fm_rdata)
  );

  // first row with a non-full word
  bba_ffz #(.W(NGROUPS)) u_grp_ffz (
    .vec    (full_grp_r),
    .found  (grp_found),
    .idx    (grp_idx),
    .onehot ()
  );

  // first non-full word in the row just read
  bba_ffz #(.W(WORD_W)) u_row_ffz (
    .vec    (fm_rdata),
    .found  (row_found),
    .idx    (row_idx),
    .onehot ()
  );

  // first clear bit in the word just read
  bba_ffz #(.W(WORD_W)) u_bit_ffz (
    .vec    (bm_rdata),
    .found  (word_found),
    .idx    (bit_idx),
    .onehot (bit_onehot)
  );

  assign in_req.ready         = (state_r == S_IDLE);
  assign cfg_wr.ready         = 1'b1;
  assign out_rsp.valid        = out_valid_r;
  assign out_rsp.result_block = out_blk_r;
  assign out_rsp.status       = out_st_r;

  // Saturate the configured count to the number of bitmap blocks built in
  assign nb_sat = (int'(cfg_wr.data) > MAX_BITMAP_BLOCKS) ? CFG_W'(MAX_BITMAP_BLOCKS)
                                                          : cfg_wr.data;

  assign row_word  = CW'({grp_r, row_idx});
  assign new_word  = bm_rdata | bit_onehot;
  assign new_row   = row_r | (word_t'(1) << wsel_r[BIT_IDX_W-1:0]);
  assign alloc_sum = SW'({wsel_r[WBITS-1:0], bit_idx}) + SW'(nb_r) + SW'(1);
  assign free_base = BLK_W'(nb_r) + BLK_W'(1);
  assign free_ind  = blk_r - free_base;
  assign free_word = CW'(free_ind[BLK_W-1:BIT_IDX_W]);

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    nb_nxt        = nb_r;
    words_nxt     = words_r;
    blk_nxt       = blk_r;
    grp_nxt       = grp_r;
    wsel_nxt      = wsel_r;
    bit_nxt       = bit_r;
    row_nxt       = row_r;
    full_grp_nxt  = full_grp_r;
    out_valid_nxt = out_valid_r;
    out_blk_nxt   = out_blk_r;
    out_st_nxt    = out_st_r;
    res_blk_nxt   = res_blk_r;
    res_st_nxt    = res_st_r;

    bm_we    = 1'b0;
    bm_waddr = wsel_r[WAW-1:0];
    bm_wdata = '0;
    bm_raddr = wsel_r[WAW-1:0];
    fm_we    = 1'b0;
    fm_waddr = grp_r;
    fm_wdata = '0;
    fm_raddr = grp_r;

    fin     = 1'b0;
    fin_blk = '0;
    fin_st  = ST_OK;

    if (cfg_wr.valid) begin
      nb_nxt    = nb_sat;
      words_nxt = CW'(nb_sat) * CW'(WORDS_PER_BITMAP_BLOCK);
    end

    // drop the response once it is taken
    if (out_valid_r && out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        bm_we    = 1'b1;
        bm_waddr = clr_r;
        bm_wdata = '0;
        if (int'(clr_r) < NGROUPS) begin
          fm_we    = 1'b1;
          fm_waddr = GAW'(clr_r);
          fm_wdata = '0;
        end
        if (clr_r == WAW'(TOTAL_WORDS - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + WAW'(1);
        end
      end

      S_IDLE: begin
        if (in_req.valid) begin
          blk_nxt   = in_req.block_number;
          state_nxt = (in_req.action == ACT_ALLOC) ? S_A_GRP : S_F_CHK;
        end
      end

      S_A_GRP: begin
        if (!grp_found) begin
          fin    = 1'b1;
          fin_st = ST_NOSPACE;
        end else begin
          fm_raddr  = grp_idx;
          grp_nxt   = grp_idx;
          state_nxt = S_A_ROW;
        end
      end

      S_A_ROW: begin
        // a word past the bitmap in use means every word in range is full
        if (!row_found || row_word >= words_r) begin
          fin    = 1'b1;
          fin_st = ST_NOSPACE;
        end else begin
          bm_raddr  = row_word[WAW-1:0];
          wsel_nxt  = row_word;
          row_nxt   = fm_rdata;
          state_nxt = S_A_WORD;
        end
      end

      S_A_WORD: begin
        bm_we    = word_found;
        bm_waddr = wsel_r[WAW-1:0];
        bm_wdata = new_word;
        if (&new_word) begin
          fm_we    = 1'b1;
          fm_waddr = grp_r;
          fm_wdata = new_row;
          if (&new_row) begin
            full_grp_nxt[grp_r] = 1'b1;
          end
        end
        fin     = 1'b1;
        fin_blk = alloc_sum[BLK_W-1:0];
        fin_st  = ST_OK;
      end

      S_F_CHK: begin
        if (blk_r < free_base || free_word >= words_r) begin
          fin    = 1'b1;
          fin_st = ST_RANGE;
        end else begin
          bm_raddr  = free_word[WAW-1:0];
          fm_raddr  = free_word[BIT_IDX_W +: GAW];
          wsel_nxt  = free_word;
          bit_nxt   = free_ind[BIT_IDX_W-1:0];
          state_nxt = S_F_WORD;
        end
      end

      S_F_WORD: begin
        bm_we    = 1'b1;
        bm_waddr = wsel_r[WAW-1:0];
        bm_wdata = bm_rdata & ~(word_t'(1) << bit_r);
        fm_we    = 1'b1;
        fm_waddr = wsel_r[BIT_IDX_W +: GAW];
        fm_wdata = fm_rdata & ~(word_t'(1) << wsel_r[BIT_IDX_W-1:0]);
        full_grp_nxt[wsel_r[BIT_IDX_W +: GAW]] = 1'b0;
        fin     = 1'b1;
        fin_blk = blk_r;
        fin_st  = ST_OK;
      end

      S_RESP: begin
        if (!out_valid_r || out_rsp.ready) begin
          out_valid_nxt = 1'b1;
          out_blk_nxt   = res_blk_r;
          out_st_nxt    = res_st_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // finished request: load the output register, or hold it until free
    if (fin) begin
      if (!out_valid_r || out_rsp.ready) begin
        out_valid_nxt = 1'b1;
        out_blk_nxt   = fin_blk;
        out_st_nxt    = fin_st;
        state_nxt     = S_IDLE;
      end else begin
        res_blk_nxt = fin_blk;
        res_st_nxt  = fin_st;
        state_nxt   = S_RESP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      nb_r        <= NB_RESET;
      words_r     <= CW'(WORDS_PER_BITMAP_BLOCK);
      full_grp_r  <= '0;
      out_valid_r <= 1'b0;
      out_blk_r   <= '0;
      out_st_r    <= ST_OK;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      nb_r        <= nb_nxt;
      words_r     <= words_nxt;
      full_grp_r  <= full_grp_nxt;
      out_valid_r <= out_valid_nxt;
      out_blk_r   <= out_blk_nxt;
      out_st_r    <= out_st_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    blk_r     <= blk_nxt;
    grp_r     <= grp_nxt;
    wsel_r    <= wsel_nxt;
    bit_r     <= bit_nxt;
    row_r     <= row_nxt;
    res_blk_r <= res_blk_nxt;
    res_st_r  <= res_st_nxt;
  end

endmodule
